>>> sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache: the request and
// response beats, the controller states and the register map.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Register map: one register, byte addresses on a 4-byte stride.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] CFG_IDX_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in the action field.
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    // Request beat.
    typedef struct packed {
        logic                    action;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    // Response beat.
    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
    } rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

endpackage

>>> sv/lkv_cfg.sv
// ----------------------------------------------------------------------------
// lkv_cfg
// APB register block. Holds the capacity register and presents the capacity
// in effect, clamped to the range 1..DEPTH.
// ----------------------------------------------------------------------------
module lkv_cfg #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkv_pkg::ADDR_W-1:0]  paddr,
    input  logic [lkv_pkg::DATA_W-1:0]  pwdata,
    output logic [lkv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [$clog2(DEPTH+1)-1:0]  eff_capacity
);
    import lkv_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CAP_W-1:0] cap_reg;
    logic [0:0]       reg_idx;
    logic             wr_en;

    // Register index is the word address.
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && (reg_idx == CFG_IDX_CAPACITY);

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (wr_en)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Read-back mux.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == CFG_IDX_CAPACITY)
        begin
            prdata = DATA_W'(cap_reg);
        end
    end

    // Clamp the capacity to 1..DEPTH.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_capacity = CW'(1);
        end
        else if (32'(cap_reg) > DEPTH)
        begin
            eff_capacity = CW'(DEPTH);
        end
        else
        begin
            eff_capacity = CW'(cap_reg);
        end
    end

endmodule

>>> sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
// Entries (key, value, age rank) live in one synchronous RAM; valid bits
// and the fill count live in flip-flops.
// ----------------------------------------------------------------------------
// The response beat is presented out of the decision step, after the lookup
// pass, and waits there while an earlier, stalled response holds the output.
// A get miss makes only the lookup pass; a hit or a set then also makes a rank
// read-modify-write pass, and no new request is taken until the last pass ends.
// Both passes go over the entry RAM through its one read port.
// Reset clears all valid bits and the fill count at once; no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lkv_pkg::req_t               in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lkv_pkg::rsp_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkv_pkg::ADDR_W-1:0]  paddr,
    input  logic [lkv_pkg::DATA_W-1:0]  pwdata,
    output logic [lkv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import lkv_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_W + VAL_W + IW;

    // Configuration.
    logic [CW-1:0] eff_capacity;

    lkv_cfg #(
        .DEPTH (DEPTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .eff_capacity (eff_capacity)
    );

    // Control state.
    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic [CW-1:0]     used_reg, used_next;
    logic              out_valid_reg, out_valid_next;
    logic              hit_reg, hit_next;
    logic              old_found_reg, old_found_next;
    logic              free_found_reg, free_found_next;

    // Payload state.
    req_t              req_reg, req_next;
    rsp_t              out_data_reg, out_data_next;
    logic [IW-1:0]     proc_idx_reg;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic [IW-1:0]     hit_rank_reg, hit_rank_next;
    logic [VAL_W-1:0]  hit_val_reg, hit_val_next;
    logic [IW-1:0]     old_idx_reg, old_idx_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [IW-1:0]     tgt_idx_reg, tgt_idx_next;
    logic [VAL_W-1:0]  tgt_val_reg, tgt_val_next;
    logic [IW-1:0]     lim_rank_reg, lim_rank_next;
    logic              insert_reg, insert_next;

    // Entry RAM.
    logic [EW-1:0]     mem [DEPTH];
    logic [EW-1:0]     rd_data_reg;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [IW-1:0]     mem_raddr;
    logic [EW-1:0]     mem_wdata;

    // Fields of the entry read in the previous cycle.
    logic [KEY_W-1:0]  d_key;
    logic [VAL_W-1:0]  d_val;
    logic [IW-1:0]     d_rank;
    logic              p_valid;
    logic [IW-1:0]     old_rank;
    logic              evict;
    logic              slot_ok;
    logic [IW-1:0]     slot;
    logic [IW-1:0]     new_rank;

    assign d_key    = rd_data_reg[EW-1 -: KEY_W];
    assign d_val    = rd_data_reg[IW +: VAL_W];
    assign d_rank   = rd_data_reg[IW-1:0];
    assign p_valid  = valid_reg[proc_idx_reg];
    assign old_rank = IW'(used_reg - CW'(1));

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // RAM: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Next state, RAM control and result.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg;
        hit_next        = hit_reg;
        old_found_next  = old_found_reg;
        free_found_next = free_found_reg;
        req_next        = req_reg;
        out_data_next   = out_data_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_val_next    = hit_val_reg;
        old_idx_next    = old_idx_reg;
        free_idx_next   = free_idx_reg;
        tgt_idx_next    = tgt_idx_reg;
        tgt_val_next    = tgt_val_reg;
        lim_rank_next   = lim_rank_reg;
        insert_next     = insert_reg;
        mem_we          = 1'b0;
        mem_waddr       = proc_idx_reg;
        mem_raddr       = cnt_reg[IW-1:0];
        mem_wdata       = rd_data_reg;
        evict           = 1'b0;
        slot_ok         = 1'b0;
        slot            = free_idx_reg;
        new_rank        = d_rank;

        // The response register empties when its beat is taken.
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = in_data;
                    hit_next        = 1'b0;
                    old_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Look at the entry read last cycle: key match, oldest entry,
                // first free slot. The first match of each kind wins.
                if (cnt_reg != '0)
                begin
                    if (p_valid && (d_key == req_reg.key) && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = proc_idx_reg;
                        hit_rank_next = d_rank;
                        hit_val_next  = d_val;
                    end
                    if (p_valid && (d_rank == old_rank) && !old_found_reg)
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = proc_idx_reg;
                    end
                    if (!p_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx_reg;
                    end
                end
                if (cnt_reg == CW'(DEPTH))
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_DECIDE:
            begin
                // Wait here until the response register can take the beat.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.found      = hit_reg;
                    out_data_next.evicted    = 1'b0;
                    out_data_next.read_value = '0;
                    cnt_next                 = '0;
                    state_next               = ST_IDLE;
                    if (req_reg.action == ACT_GET)
                    begin
                        out_data_next.read_value = hit_reg ? hit_val_reg : '1;
                    end
                    if (hit_reg)
                    begin
                        // Hit: refresh the entry, set also replaces the value.
                        tgt_idx_next  = hit_idx_reg;
                        tgt_val_next  = (req_reg.action == ACT_SET) ? req_reg.value
                                                                    : hit_val_reg;
                        lim_rank_next = hit_rank_reg;
                        insert_next   = 1'b0;
                        state_next    = ST_UPDATE;
                    end
                    else if (req_reg.action == ACT_SET)
                    begin
                        // Miss on set: evict the oldest when full, then insert.
                        evict   = (used_reg >= eff_capacity) && (used_reg != '0)
                                  && old_found_reg;
                        slot_ok = evict || free_found_reg;
                        if (evict && (!free_found_reg || (old_idx_reg < free_idx_reg)))
                        begin
                            slot = old_idx_reg;
                        end
                        out_data_next.evicted = evict;
                        if (evict)
                        begin
                            valid_next[old_idx_reg] = 1'b0;
                        end
                        if (slot_ok)
                        begin
                            valid_next[slot] = 1'b1;
                            used_next        = evict ? used_reg : used_reg + CW'(1);
                            tgt_idx_next     = slot;
                            tgt_val_next     = req_reg.value;
                            insert_next      = 1'b1;
                            state_next       = ST_UPDATE;
                        end
                        else if (evict)
                        begin
                            used_next = used_reg - CW'(1);
                        end
                    end
                end
            end

            ST_UPDATE:
            begin
                // Write back the entry read last cycle with its new rank.
                if (cnt_reg != '0)
                begin
                    if (proc_idx_reg == tgt_idx_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {req_reg.key, tgt_val_reg, {IW{1'b0}}};
                    end
                    else if (p_valid)
                    begin
                        if (insert_reg || (d_rank < lim_rank_reg))
                        begin
                            new_rank = d_rank + IW'(1);
                        end
                        mem_we    = 1'b1;
                        mem_wdata = {d_key, d_val, new_rank};
                    end
                end
                if (cnt_reg == CW'(DEPTH))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            old_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
            hit_reg        <= hit_next;
            old_found_reg  <= old_found_next;
            free_found_reg <= free_found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
        proc_idx_reg <= cnt_reg[IW-1:0];
        hit_idx_reg  <= hit_idx_next;
        hit_rank_reg <= hit_rank_next;
        hit_val_reg  <= hit_val_next;
        old_idx_reg  <= old_idx_next;
        free_idx_reg <= free_idx_next;
        tgt_idx_reg  <= tgt_idx_next;
        tgt_val_reg  <= tgt_val_next;
        lim_rank_reg <= lim_rank_next;
        insert_reg   <= insert_next;
    end

    // The fill count always matches the number of valid entries when idle.
    a_used_matches_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_reg) == 32'(used_reg))
    ) else $error("fill count does not match valid bits");

    // A response beat is only produced out of the decision step.
    a_rsp_from_decide: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DECIDE)
    ) else $error("response raised outside the decision step");

    // An eviction only happens on a miss.
    a_evict_on_miss: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.evicted && out_data_reg.found)
    ) else $error("eviction reported on a hit");

    // An accepted request starts the lookup pass in the next cycle.
    a_accept_starts_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SCAN) && (cnt_reg == '0)
    ) else $error("accepted request did not start the lookup pass");

endmodule

>>> tb/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key-value cache. A driver sends get and set
// beats from a backlog queue, a scoreboard model of the cache predicts each
// response at acceptance, and a monitor compares every response beat field by
// field. The capacity register is rewritten between phases over APB, with
// both channels idling in random bursts until the final phase.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

    import lkv_pkg::*;

    localparam int CACHE_DEPTH = 16;
    // Quiet cycles after the last response; a hit or set keeps the block busy
    // with its rank pass well past the response.
    localparam int DRAIN_CYCLES = 2 * CACHE_DEPTH + 8;
    localparam int POOL_SIZE = 24;
    localparam int RANDOM_PER_PHASE = 125;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    req_t                in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    rsp_t                out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    lru_key_value_cache #(
        .DEPTH(CACHE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock: 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Scoreboard copy of the cache contents and the capacity register.
    logic [KEY_W-1:0] model_key [CACHE_DEPTH];
    logic [VAL_W-1:0] model_val [CACHE_DEPTH];
    bit               model_live [CACHE_DEPTH];
    int               model_rank [CACHE_DEPTH];
    int               model_fill = 0;
    logic [CAP_W-1:0] model_cap = CAP_RESET;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   outstanding_items = 0;
    int   mismatch_count = 0;
    bit   idle_on = 1'b1;
    int   src_gap = 0;
    int   sink_gap = 0;
    rsp_t exp_beat;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // Entries younger than idx age by one; idx becomes the most recent.
    function automatic void make_most_recent(input int idx);
        int r;
        r = model_rank[idx];
        for (int i = 0; i < CACHE_DEPTH; i++)
        begin
            if (model_live[i] && model_rank[i] < r)
                model_rank[i]++;
        end
        model_rank[idx] = 0;
    endfunction

    // Apply one request to the scoreboard cache and return its response.
    function automatic rsp_t lru_access(input req_t rq);
        rsp_t r;
        int   hit;
        int   slot;
        int   cap_eff;
        bit   gone;
        hit = -1;
        slot = -1;
        gone = 1'b0;
        for (int i = 0; i < CACHE_DEPTH; i++)
        begin
            if (hit < 0 && model_live[i] && model_key[i] == rq.key)
                hit = i;
        end
        r.found = (hit >= 0);
        r.read_value = '0;
        r.evicted = 1'b0;
        if (rq.action == ACT_GET)
        begin
            if (hit >= 0)
            begin
                r.read_value = model_val[hit];
                make_most_recent(hit);
            end
            else
            begin
                r.read_value = '1;
            end
        end
        else if (hit >= 0)
        begin
            model_val[hit] = rq.value;
            make_most_recent(hit);
        end
        else
        begin
            // Clamp the capacity to 1..DEPTH; a full store drops its oldest.
            cap_eff = int'(model_cap);
            if (cap_eff < 1)
                cap_eff = 1;
            if (cap_eff > CACHE_DEPTH)
                cap_eff = CACHE_DEPTH;
            if (model_fill >= cap_eff && model_fill > 0)
            begin
                for (int i = 0; i < CACHE_DEPTH; i++)
                begin
                    if (!gone && model_live[i] && model_rank[i] == model_fill - 1)
                    begin
                        model_live[i] = 1'b0;
                        model_fill--;
                        r.evicted = 1'b1;
                        gone = 1'b1;
                    end
                end
            end
            for (int i = 0; i < CACHE_DEPTH; i++)
            begin
                if (slot < 0 && !model_live[i])
                    slot = i;
            end
            if (slot >= 0)
            begin
                for (int i = 0; i < CACHE_DEPTH; i++)
                begin
                    if (model_live[i])
                        model_rank[i]++;
                end
                model_key[slot] = rq.key;
                model_val[slot] = rq.value;
                model_live[slot] = 1'b1;
                model_rank[slot] = 0;
                model_fill++;
            end
        end
        return r;
    endfunction

    // Request driver: predicts each accepted beat and idles in short bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            src_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_rsps = {expected_rsps, lru_access(in_data)};
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && pending_reqs.size() != 0 && $urandom_range(0, 5) == 0)
                begin
                    src_gap = $urandom_range(0, 3);
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each accepted beat and stalls in short bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response beat: found=%0b read_value=%h evicted=%0b",
                           out_data.found, out_data.read_value, out_data.evicted);
                    mismatch_count++;
                end
                else
                begin
                    exp_beat = expected_rsps.pop_front();
                    outstanding_items--;
                    if (out_data.found !== exp_beat.found)
                    begin
                        $error("found: expected %0b, actual %0b",
                               exp_beat.found, out_data.found);
                        mismatch_count++;
                    end
                    if (out_data.read_value !== exp_beat.read_value)
                    begin
                        $error("read_value: expected %h, actual %h",
                               exp_beat.read_value, out_data.read_value);
                        mismatch_count++;
                    end
                    if (out_data.evicted !== exp_beat.evicted)
                    begin
                        $error("evicted: expected %0b, actual %0b",
                               exp_beat.evicted, out_data.evicted);
                        mismatch_count++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_req(input logic act, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
        req_t rq;
        rq.action = act;
        rq.key = k;
        rq.value = v;
        outstanding_items++;
        pending_reqs = {pending_reqs, rq};
    endtask

    // Wait until every response has arrived and the block has gone quiet.
    task automatic wait_drained();
        while (outstanding_items != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr >> 2 == int'(CFG_IDX_CAPACITY))
            model_cap = data[CAP_W-1:0];
    endtask

    // Set the capacity with random upper bits, then run a random phase.
    task automatic run_random_phase(input logic [CAP_W-1:0] cap);
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        int span;
        apb_write(ADDR_W'(4 * int'(CFG_IDX_CAPACITY)),
                  {DATA_W'($urandom) & ~DATA_W'(5'h1F)} | DATA_W'(cap));
        // Key pool about twice the capacity keeps hits and evictions frequent.
        span = 2 * int'(cap) + 2;
        if (span > POOL_SIZE)
            span = POOL_SIZE;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            if ($urandom_range(0, 9) < 8)
                k = key_pool[$urandom_range(0, span - 1)];
            else
                k = $urandom;
            case ($urandom_range(0, 11))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            push_req($urandom_range(0, 1) ? ACT_SET : ACT_GET, k, v);
        end
        wait_drained();
    endtask

    // Stimulus sequence.
    initial
    begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        for (int i = 0; i < CACHE_DEPTH; i++)
        begin
            model_live[i] = 1'b0;
            model_rank[i] = 0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: miss on empty, extreme keys and values, hits and updates.
        push_req(ACT_GET, 32'h0000_0000, 32'h5A5A_5A5A);
        push_req(ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        push_req(ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        push_req(ACT_SET, 32'h0000_0000, 32'h0000_0000);
        push_req(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        push_req(ACT_SET, 32'h8000_0000, 32'h1234_5678);
        push_req(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        push_req(ACT_GET, 32'h0000_0001, 32'h0000_0000);
        wait_drained();

        // Capacity lowered below the fill: each new key evicts one entry.
        apb_write(ADDR_W'(4 * int'(CFG_IDX_CAPACITY)), 32'h0000_0002);
        push_req(ACT_SET, 32'h0000_0005, 32'hA5A5_A5A5);
        push_req(ACT_SET, 32'h0000_0006, 32'h5A5A_5A5A);
        push_req(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        push_req(ACT_GET, 32'h0000_0006, 32'h0000_0000);
        push_req(ACT_SET, 32'h0000_0006, 32'hDEAD_BEEF);
        wait_drained();

        // Out-of-range register index is ignored; capacity zero acts as one.
        apb_write(ADDR_W'(4), 32'h0000_0001);
        apb_write(ADDR_W'(4 * int'(CFG_IDX_CAPACITY)), 32'hFFFF_FFE0);
        push_req(ACT_SET, 32'h0000_0007, 32'h0F0F_0F0F);
        push_req(ACT_GET, 32'h0000_0006, 32'h0000_0000);
        push_req(ACT_SET, 32'h0000_0008, 32'hF0F0_F0F0);
        push_req(ACT_GET, 32'h0000_0008, 32'h0000_0000);
        push_req(ACT_GET, 32'h0000_0007, 32'h0000_0000);
        wait_drained();

        // Random phases over capacities above DEPTH, at the extremes and between.
        run_random_phase(5'd31);
        run_random_phase(5'd1);
        run_random_phase(5'd16);
        run_random_phase(5'd3);
        run_random_phase(5'd17);
        run_random_phase(5'd8);
        run_random_phase(5'd0);
        idle_on = 1'b0;
        run_random_phase(5'd12);

        if (mismatch_count == 0)
            $display("lru_key_value_cache test passed");
        else
            $display("lru_key_value_cache test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("lru_key_value_cache test failed");
        $finish;
    end

endmodule
